// ===== src/zbuffer_triangle_rasterizer_core_macros.svh =====
// Assertion macros for the rasterizer core RTL.
`ifndef ZBUFFER_TRIANGLE_RASTERIZER_CORE_MACROS_SVH
`define ZBUFFER_TRIANGLE_RASTERIZER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ZBR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ZBR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== src/zbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbr_pkg
// Shared types and constants of the z-buffer triangle rasterizer.
// ----------------------------------------------------------------------------
package zbr_pkg;
   localparam int FrameWidthDefault  = 256;
   localparam int FrameHeightDefault = 256;
   localparam int CoordWidth = 16;
   localparam int ColorWidth = 24;
   localparam int DepthWidth = 32;
   localparam int CountWidth = 17;
   localparam int IndexWidth = 16;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [CoordWidth-1:0]  v0_x, v0_y, v0_z;
      logic signed [CoordWidth-1:0]  v1_x, v1_y, v1_z;
      logic signed [CoordWidth-1:0]  v2_x, v2_y, v2_z;
      logic [ColorWidth-1:0]         fill_color;
      logic [IndexWidth-1:0]         pixel_index;
   } req_type;

   typedef struct packed {
      logic [ColorWidth-1:0]         read_color;
      logic signed [DepthWidth-1:0]  read_depth;
      logic [CountWidth-1:0]         pixels_written;
   } rsp_type;

   // Divider handshake between the core and its divider.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_sts_type;
endpackage

// ===== src/zbr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbr_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface zbr_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/zbuffer_triangle_rasterizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbuffer_triangle_rasterizer_core
// Z-buffered triangle rasterizer with depth and color frame memories.
// ----------------------------------------------------------------------------
// Commands: clear, draw, read, nop. A read latches the addressed entry in S_READ
// and posts it from S_RESP. A clear and the pass after reset sweep all entries,
// FRAME_WIDTH*FRAME_HEIGHT (65536 at the default size), one entry a cycle; no
// request is taken during the sweep. A draw runs setup in S_SETUP1, S_SETUP2 and
// S_SETUP3, then visits every pixel of its clamped bounding box, where an inside
// pixel waits for the bit-serial depth divider, and posts the result from S_RESP;
// the read-compare-write to the memories hides under the divide.
`include "zbuffer_triangle_rasterizer_core_macros.svh"
module zbuffer_triangle_rasterizer_core import zbr_pkg::*; #(
   parameter int FRAME_WIDTH  = FrameWidthDefault,
   parameter int FRAME_HEIGHT = FrameHeightDefault
) (
   input logic clock,
   input logic reset,
   zbr_if.sink   req,
   zbr_if.source rsp
);
   localparam int NumPixels = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AddrWidth = $clog2(NumPixels);
   localparam int XWidth = $clog2(FRAME_WIDTH);
   localparam int YWidth = $clog2(FRAME_HEIGHT);
   localparam int NumWidth = 72;
   localparam int DenWidth = 40;
   localparam logic signed [DepthWidth-1:0] DepthFloor = {1'b1, {(DepthWidth-1){1'b0}}};

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_SETUP1, S_SETUP2, S_SETUP3, S_PIX,
      S_EDGE, S_DIVWAIT, S_CMP, S_NEXT, S_RESP
   } state_type;

   state_type state_ff;
   req_type   r_ff;
   rsp_type   out_ff;
   logic      out_valid_ff;
   logic [AddrWidth-1:0] clr_ff;

   logic signed [DepthWidth-1:0] depth_mem [NumPixels];
   logic [ColorWidth-1:0]        color_mem [NumPixels];
   logic signed [DepthWidth-1:0] depth_rd_ff;
   logic [ColorWidth-1:0]        color_rd_ff;
   logic [AddrWidth-1:0]         rd_addr, wr_addr;
   logic                         wr_en;
   logic signed [DepthWidth-1:0] wr_depth;
   logic [ColorWidth-1:0]        wr_color;

   // Plane and bounding box.
   logic signed [17:0] ex1_ff, ey1_ff, ez1_ff, ex2_ff, ey2_ff, ez2_ff;
   logic signed [35:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [DenWidth-1:0] pa_ff, pb_ff, pc_ff;
   logic signed [NumWidth-1:0] pd_ff;
   logic signed [XWidth+1:0] lox_ff, hix_ff;
   logic signed [YWidth+1:0] loy_ff, hiy_ff;
   logic [XWidth:0] x_ff;
   logic [YWidth:0] y_ff;
   logic [CountWidth-1:0] count_ff;
   logic signed [NumWidth-1:0] num_ff;
   logic inside_ff;
   logic signed [NumWidth-1:0] quot;
   logic [2:0] setup_step_ff;

   div_ctl_type div_ctl;
   div_sts_type div_sts;

   // Integer part of a Q12.4 value, truncated toward zero.
   function automatic logic signed [17:0] trunc16(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = 17'(v);
      if (w < 0) w = w + 17'sd15;
      return 18'(w >>> 4);
   endfunction

   function automatic logic signed [17:0] min3(input logic signed [17:0] a, b, c);
      logic signed [17:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [17:0] max3(input logic signed [17:0] a, b, c);
      logic signed [17:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // Edge test: sign of (P-q) x (p-q) for one edge.
   function automatic logic edge_neg(input logic signed [20:0] px, py,
                                     input logic signed [15:0] ax, ay, bx, by);
      logic signed [44:0] dx, dy, ex, ey;
      logic signed [44:0] s;
      dx = 45'(px) - 45'(bx); dy = 45'(ay) - 45'(by);
      ex = 45'(ax) - 45'(bx); ey = 45'(py) - 45'(by);
      s = dx * dy - ex * ey;
      return s[44];
   endfunction

   logic signed [20:0] px_w, py_w;
   logic s1, s2, s3;
   assign px_w = 21'($signed({1'b0, x_ff})) <<< 4;
   assign py_w = 21'($signed({1'b0, y_ff})) <<< 4;
   assign s1 = edge_neg(px_w, py_w, r_ff.v0_x, r_ff.v0_y, r_ff.v1_x, r_ff.v1_y);
   assign s2 = edge_neg(px_w, py_w, r_ff.v1_x, r_ff.v1_y, r_ff.v2_x, r_ff.v2_y);
   assign s3 = edge_neg(px_w, py_w, r_ff.v2_x, r_ff.v2_y, r_ff.v0_x, r_ff.v0_y);

   logic [AddrWidth-1:0] pix_addr;
   assign pix_addr = AddrWidth'(y_ff * FRAME_WIDTH + x_ff);

   zbr_divider #(.NumWidth(NumWidth), .DenWidth(DenWidth)) u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl),
      .numer(-num_ff), .denom(pc_ff), .sts(div_sts), .quot(quot)
   );

   // Saturated depth from the quotient.
   logic signed [DepthWidth-1:0] z_sat;
   always_comb begin
      if (quot > NumWidth'(64'sh7FFFFFFF)) z_sat = {1'b0, {(DepthWidth-1){1'b1}}};
      else if (quot < -NumWidth'(64'sh80000000)) z_sat = DepthFloor;
      else z_sat = quot[DepthWidth-1:0];
   end

   always_comb begin
      rd_addr = (state_ff == S_IDLE) ? r_ff.pixel_index[AddrWidth-1:0] : pix_addr;
      if (state_ff == S_IDLE) rd_addr = req.data.pixel_index[AddrWidth-1:0];
      wr_en = 1'b0; wr_addr = pix_addr; wr_depth = z_sat; wr_color = r_ff.fill_color;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1; wr_addr = clr_ff; wr_depth = DepthFloor; wr_color = '0;
      end else if (state_ff == S_CMP && z_sat > depth_rd_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         depth_mem[wr_addr] <= wr_depth;
         color_mem[wr_addr] <= wr_color;
      end
      depth_rd_ff <= depth_mem[rd_addr];
      color_rd_ff <= color_mem[rd_addr];
   end

   assign req.ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
   assign div_ctl.start = (state_ff == S_EDGE) && inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; out_valid_ff <= 1'b0;
         setup_step_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AddrWidth'(NumPixels - 1)) begin
                  state_ff <= (r_ff.command == CMD_CLEAR && setup_step_ff[0])
                              ? S_RESP : S_IDLE;
                  out_ff <= '0;
               end
            end
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  r_ff <= req.data;
                  out_ff <= '0;
                  setup_step_ff <= 3'd1;
                  unique case (command_type'(req.data.command))
                     CMD_CLEAR: begin state_ff <= S_CLEAR; clr_ff <= '0; end
                     CMD_DRAW:  state_ff <= S_SETUP1;
                     CMD_READ:  state_ff <= S_READ;
                     CMD_NOP:   state_ff <= S_RESP;
                  endcase
               end
            end
            S_READ: begin
               if (32'(r_ff.pixel_index) < 32'(NumPixels)) begin
                  out_ff.read_color <= color_rd_ff;
                  out_ff.read_depth <= depth_rd_ff;
               end
               state_ff <= S_RESP;
            end
            S_SETUP1: begin
               ex1_ff <= 18'(r_ff.v1_x) - 18'(r_ff.v0_x);
               ey1_ff <= 18'(r_ff.v1_y) - 18'(r_ff.v0_y);
               ez1_ff <= 18'(r_ff.v1_z) - 18'(r_ff.v0_z);
               ex2_ff <= 18'(r_ff.v2_x) - 18'(r_ff.v0_x);
               ey2_ff <= 18'(r_ff.v2_y) - 18'(r_ff.v0_y);
               ez2_ff <= 18'(r_ff.v2_z) - 18'(r_ff.v0_z);
               lox_ff <= (XWidth+2)'(min3(trunc16(r_ff.v0_x), trunc16(r_ff.v1_x),
                                           trunc16(r_ff.v2_x)) > FRAME_WIDTH ? FRAME_WIDTH :
                         (min3(trunc16(r_ff.v0_x), trunc16(r_ff.v1_x), trunc16(r_ff.v2_x)) < 0
                          ? 0 : min3(trunc16(r_ff.v0_x), trunc16(r_ff.v1_x),
                                     trunc16(r_ff.v2_x))));
               hix_ff <= (XWidth+2)'(max3(trunc16(r_ff.v0_x), trunc16(r_ff.v1_x),
                                           trunc16(r_ff.v2_x)) < 0 ? 0 :
                         (max3(trunc16(r_ff.v0_x), trunc16(r_ff.v1_x), trunc16(r_ff.v2_x))
                          > FRAME_WIDTH - 1 ? FRAME_WIDTH - 1 :
                          max3(trunc16(r_ff.v0_x), trunc16(r_ff.v1_x), trunc16(r_ff.v2_x))));
               loy_ff <= (YWidth+2)'(min3(trunc16(r_ff.v0_y), trunc16(r_ff.v1_y),
                                           trunc16(r_ff.v2_y)) > FRAME_HEIGHT ? FRAME_HEIGHT :
                         (min3(trunc16(r_ff.v0_y), trunc16(r_ff.v1_y), trunc16(r_ff.v2_y)) < 0
                          ? 0 : min3(trunc16(r_ff.v0_y), trunc16(r_ff.v1_y),
                                     trunc16(r_ff.v2_y))));
               hiy_ff <= (YWidth+2)'(max3(trunc16(r_ff.v0_y), trunc16(r_ff.v1_y),
                                           trunc16(r_ff.v2_y)) < 0 ? 0 :
                         (max3(trunc16(r_ff.v0_y), trunc16(r_ff.v1_y), trunc16(r_ff.v2_y))
                          > FRAME_HEIGHT - 1 ? FRAME_HEIGHT - 1 :
                          max3(trunc16(r_ff.v0_y), trunc16(r_ff.v1_y), trunc16(r_ff.v2_y))));
               count_ff <= '0;
               state_ff <= S_SETUP2;
            end
            S_SETUP2: begin
               m0_ff <= ey1_ff * ez2_ff; m1_ff <= ez1_ff * ey2_ff;
               m2_ff <= ez1_ff * ex2_ff; m3_ff <= ex1_ff * ez2_ff;
               m4_ff <= ex1_ff * ey2_ff; m5_ff <= ey1_ff * ex2_ff;
               state_ff <= S_SETUP3;
               setup_step_ff <= 3'd0;
            end
            S_SETUP3: begin
               // Step 0 forms A, B, C; steps 1..3 accumulate D one product each.
               unique case (setup_step_ff)
                  3'd0: begin
                     pa_ff <= DenWidth'(m0_ff) - DenWidth'(m1_ff);
                     pb_ff <= DenWidth'(m2_ff) - DenWidth'(m3_ff);
                     pc_ff <= DenWidth'(m4_ff) - DenWidth'(m5_ff);
                     pd_ff <= '0;
                  end
                  3'd1: pd_ff <= pd_ff - pa_ff * r_ff.v0_x;
                  3'd2: pd_ff <= pd_ff - pb_ff * r_ff.v0_y;
                  3'd3: pd_ff <= pd_ff - pc_ff * r_ff.v0_z;
                  default: ;
               endcase
               setup_step_ff <= setup_step_ff + 1'b1;
               if (setup_step_ff == 3'd3) begin
                  x_ff <= lox_ff[XWidth:0];
                  y_ff <= loy_ff[YWidth:0];
                  if (pc_ff == '0 || lox_ff > hix_ff || loy_ff > hiy_ff) begin
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_PIX;
                  end
               end
            end
            S_PIX: begin
               inside_ff <= (s1 == s2) && (s2 == s3);
               num_ff <= pa_ff * px_w + pb_ff * py_w + pd_ff;
               state_ff <= S_EDGE;
            end
            S_EDGE: state_ff <= inside_ff ? S_DIVWAIT : S_NEXT;
            S_DIVWAIT: if (div_sts.done) state_ff <= S_CMP;
            S_CMP: begin
               if (z_sat > depth_rd_ff && count_ff != {CountWidth{1'b1}})
                  count_ff <= count_ff + 1'b1;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if ((YWidth+2)'(y_ff) == hiy_ff) begin
                  y_ff <= loy_ff[YWidth:0];
                  if ((XWidth+2)'(x_ff) == hix_ff) begin
                     out_ff.pixels_written <= count_ff;
                     state_ff <= S_RESP;
                  end else begin
                     x_ff <= x_ff + 1'b1;
                     state_ff <= S_PIX;
                  end
               end else begin
                  y_ff <= y_ff + 1'b1;
                  state_ff <= S_PIX;
               end
            end
            S_RESP: begin
               out_valid_ff <= 1'b1;
               setup_step_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ZBR_ASSERT_IMP(a_no_req_busy, state_ff != S_IDLE, !req.ready, "request taken while busy")
   `ZBR_ASSERT_IMP(a_clear_no_rsp, state_ff == S_CLEAR, !rsp.valid, "result during sweep")
   `ZBR_ASSERT_NEXT(a_cmp_after_div, state_ff == S_DIVWAIT && div_sts.done, state_ff == S_CMP, "depth compare skipped")
endmodule

// ===== src/zbr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbr_divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module zbr_divider import zbr_pkg::*; #(
   parameter int NumWidth = 72,
   parameter int DenWidth = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  div_ctl_type                 ctl,
   input  logic signed [NumWidth-1:0]  numer,
   input  logic signed [DenWidth-1:0]  denom,
   output div_sts_type                 sts,
   output logic signed [NumWidth-1:0]  quot
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [DenWidth-1:0] d_ff, d_in;
   logic                neg_ff, neg_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DenWidth:0]   trial;
   logic [NumWidth-1:0] abs_n;
   logic [DenWidth-1:0] abs_d;

   always_comb begin
      abs_n = numer[NumWidth-1] ? NumWidth'(-numer) : NumWidth'(numer);
      abs_d = denom[DenWidth-1] ? DenWidth'(-denom) : DenWidth'(denom);
      trial = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (ctl.start) begin
         q_in = abs_n; r_in = '0; d_in = abs_d;
         neg_in = numer[NumWidth-1] ^ denom[DenWidth-1];
         cnt_in = CntWidth'(NumWidth); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign quot = neg_ff ? NumWidth'(-q_ff) : NumWidth'(q_ff);
   assign sts.done = done_ff;
   assign sts.busy = busy_ff;
endmodule
